/* rtl/core/cwps_pkg.sv */
// Shared widths, codes and controller/datapath interface types for the
// circular window profile statistics block. No dependencies.
package cwps_pkg;

    localparam int VALUE_W     = 24;
    localparam int PHASE_W     = 16;
    localparam int IDX_OUT_W   = 16;
    localparam int BIN_IDX_W   = 12;
    localparam int CFG_W       = 13;
    localparam int TOT_W       = 41;
    localparam int TABS_W      = 40;
    localparam int TSQ_W       = 62;
    localparam int SQ_W        = 2 * VALUE_W;

    localparam logic [CFG_W-1:0] ACTIVE_BINS_RST = 13'd4096;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [PHASE_W-1:0] phase_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic write_bin;        // store one bin
        logic load_query;       // latch window, start remainder of the start magnitude
        logic set_start;        // normalize start, set read pointer
        logic load_end_div;     // start remainder of start minus end
        logic set_count_direct; // window length is end minus start
        logic set_count_wrap;   // window length is bins minus remainder
        logic walk;             // read one bin, advance pointer
    } cwps_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed
    {
        logic rem_busy;
        logic end_wraps;
        logic walk_last;
        logic pipe_busy;
    } cwps_status_t;

endpackage

/* rtl/core/cwps_rem.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on nothing.
module cwps_rem #(
    parameter int DW = 17,
    parameter int NW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] x_reg;
    logic [NW-1:0] r_reg;
    logic [NW-1:0] d_reg;
    logic [NW:0]   shifted;
    logic [NW:0]   diff;
    logic [NW-1:0] r_next;

    always_comb
    begin
        shifted = {r_reg, x_reg[DW-1]};
        diff    = shifted - {1'b0, d_reg};
        if (shifted >= {1'b0, d_reg})
        begin
            r_next = diff[NW-1:0];
        end
        else
        begin
            r_next = shifted[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            x_reg <= x_reg << 1;
            r_reg <= r_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign rem  = r_reg;

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (r_reg < d_reg))
        else $error("partial remainder not below divisor");

endmodule

/* rtl/core/cwps_ctrl.sv */
// Controller state machine: sequences normalization, the window walk and
// the result strobe. Depends on cwps_pkg.
module cwps_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cwps_pkg::opcode_t     opcode,
    input  cwps_pkg::cwps_status_t status,
    output cwps_pkg::cwps_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);

    import cwps_pkg::*;

    typedef enum logic [6:0]
    {
        ST_IDLE  = 7'b0000001,
        ST_DIV_S = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_DIV_E = 7'b0001000,
        ST_WALK  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_DIV_S;
                    end
                    else
                    begin
                        cmd.write_bin = 1'b1;
                    end
                end
            end
            ST_DIV_S:
            begin
                if (!status.rem_busy)
                begin
                    cmd.set_start = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.end_wraps)
                begin
                    cmd.load_end_div = 1'b1;
                    state_next       = ST_DIV_E;
                end
                else
                begin
                    cmd.set_count_direct = 1'b1;
                    state_next           = ST_WALK;
                end
            end
            ST_DIV_E:
            begin
                if (!status.rem_busy)
                begin
                    cmd.set_count_wrap = 1'b1;
                    state_next         = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DRAIN) && !$past(status.pipe_busy))
        else $error("result strobe without a drained pipeline");

endmodule

/* rtl/core/cwps_datapath.sv */
// Datapath: bin memory, configuration register, window normalization,
// read pointer and the statistics pipeline. Depends on cwps_pkg, cwps_rem.
module cwps_datapath #(
    parameter int MAX_BINS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cwps_pkg::cwps_cmd_t                cmd,
    output cwps_pkg::cwps_status_t             status,
    input  logic                               cfg_we,
    input  logic [cwps_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [cwps_pkg::BIN_IDX_W-1:0]     bin_index,
    input  cwps_pkg::value_t                   bin_value,
    input  cwps_pkg::phase_t                   window_start,
    input  cwps_pkg::phase_t                   window_end,
    output cwps_pkg::value_t                   max_value,
    output logic [cwps_pkg::IDX_OUT_W-1:0]     max_index,
    output cwps_pkg::value_t                   min_value,
    output logic [cwps_pkg::IDX_OUT_W-1:0]     min_index,
    output logic signed [cwps_pkg::TOT_W-1:0]  total,
    output logic [cwps_pkg::TABS_W-1:0]        total_abs,
    output logic [cwps_pkg::TSQ_W-1:0]         total_sq
);

    import cwps_pkg::*;

    localparam int AW    = $clog2(MAX_BINS);
    localparam int NW    = $clog2(MAX_BINS + 1);
    localparam int IDX_W = $clog2(32768 + MAX_BINS + 1);

    // Configuration and effective bin count
    logic [CFG_W-1:0] active_bins_reg;
    logic [NW-1:0]    n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bins_reg <= ACTIVE_BINS_RST;
        end
        else if (cfg_we)
        begin
            active_bins_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (active_bins_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(active_bins_reg) > 32'(MAX_BINS))
        begin
            n_eff = NW'(MAX_BINS);
        end
        else
        begin
            n_eff = NW'(active_bins_reg);
        end
    end

    // Window normalization
    phase_t           s_in_reg;
    phase_t           e_reg;
    logic             s_neg_reg;
    logic [IDX_W-1:0] s_reg;
    logic [AW-1:0]    p_reg;
    logic [IDX_W-1:0] cnt_reg;

    logic [PHASE_W:0]   start_ext;
    logic [PHASE_W:0]   start_neg;
    logic [PHASE_W-1:0] start_mag;
    logic [IDX_W:0]     s_cmp;
    logic [IDX_W:0]     e_ext;
    logic [IDX_W:0]     end_diff;
    logic [IDX_W:0]     direct_len;
    logic [IDX_W-1:0]   div_in;
    logic               div_load;
    logic               rem_busy;
    logic [NW-1:0]      rem;
    logic [NW-1:0]      n_minus_rem;

    always_comb
    begin
        start_ext   = {window_start[PHASE_W-1], window_start};
        start_neg   = -start_ext;
        start_mag   = window_start[PHASE_W-1] ? start_neg[PHASE_W-1:0]
                                              : $unsigned(window_start);
        s_cmp       = {1'b0, s_reg};
        e_ext       = {{(IDX_W + 1 - PHASE_W){e_reg[PHASE_W-1]}}, e_reg};
        end_diff    = s_cmp - e_ext;
        direct_len  = e_ext - s_cmp;
        div_load    = cmd.load_query | cmd.load_end_div;
        div_in      = cmd.load_query ? IDX_W'(start_mag) : end_diff[IDX_W-1:0];
        n_minus_rem = n_eff - rem;
    end

    cwps_rem #(
        .DW (IDX_W),
        .NW (NW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (div_in),
        .divisor  (n_eff),
        .busy     (rem_busy),
        .rem      (rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            s_in_reg  <= window_start;
            e_reg     <= window_end;
            s_neg_reg <= window_start[PHASE_W-1];
        end
        // Start lands in (0, n] when negative; the pointer is start mod n
        if (cmd.set_start)
        begin
            if (s_neg_reg)
            begin
                s_reg <= IDX_W'(n_eff) - IDX_W'(rem);
                p_reg <= (rem == '0) ? '0 : AW'(n_minus_rem);
            end
            else
            begin
                s_reg <= IDX_W'($unsigned(s_in_reg));
                p_reg <= AW'(rem);
            end
        end
        else if (cmd.walk)
        begin
            s_reg <= s_reg + IDX_W'(1);
            if (NW'(p_reg) == n_eff - NW'(1))
            begin
                p_reg <= '0;
            end
            else
            begin
                p_reg <= p_reg + AW'(1);
            end
        end
        if (cmd.set_count_direct)
        begin
            cnt_reg <= direct_len[IDX_W-1:0];
        end
        else if (cmd.set_count_wrap)
        begin
            cnt_reg <= IDX_W'(n_minus_rem);
        end
        else if (cmd.walk)
        begin
            cnt_reg <= cnt_reg - IDX_W'(1);
        end
    end

    // Bin memory
    value_t        mem [MAX_BINS];
    value_t        rd_data_reg;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;

    assign wr_ok   = (32'(bin_index) < 32'(MAX_BINS));
    assign wr_addr = AW'(bin_index);

    always_ff @(posedge clk)
    begin
        if (cmd.write_bin && wr_ok)
        begin
            mem[wr_addr] <= bin_value;
        end
        if (cmd.walk)
        begin
            rd_data_reg <= mem[p_reg];
        end
    end

    // Statistics pipeline: read, compare and sum, square accumulate
    logic             rd_valid_reg;
    logic             sq_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             first_reg;
    value_t           max_reg;
    value_t           min_reg;
    logic [IDX_W-1:0] maxi_reg;
    logic [IDX_W-1:0] mini_reg;
    logic signed [TOT_W-1:0] tot_reg;
    logic [TABS_W-1:0] tabs_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [TSQ_W-1:0]  tsq_reg;

    logic [VALUE_W:0]   v_ext;
    logic [VALUE_W:0]   v_neg;
    logic [VALUE_W-1:0] v_abs;
    logic [SQ_W-1:0]    v_sq;

    always_comb
    begin
        v_ext = {rd_data_reg[VALUE_W-1], rd_data_reg};
        v_neg = -v_ext;
        v_abs = rd_data_reg[VALUE_W-1] ? v_neg[VALUE_W-1:0] : $unsigned(rd_data_reg);
        v_sq  = v_abs * v_abs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.walk;
            sq_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            rd_idx_reg <= s_reg;
        end
        if (cmd.load_query)
        begin
            first_reg <= 1'b1;
            tot_reg   <= '0;
            tabs_reg  <= '0;
            tsq_reg   <= '0;
        end
        else
        begin
            if (rd_valid_reg)
            begin
                first_reg <= 1'b0;
                tot_reg   <= tot_reg + TOT_W'(rd_data_reg);
                tabs_reg  <= tabs_reg + TABS_W'(v_abs);
                sq_reg    <= v_sq;
                // Strict compares keep the first occurrence
                if (first_reg || (rd_data_reg > max_reg))
                begin
                    max_reg  <= rd_data_reg;
                    maxi_reg <= rd_idx_reg;
                end
                if (first_reg || (rd_data_reg < min_reg))
                begin
                    min_reg  <= rd_data_reg;
                    mini_reg <= rd_idx_reg;
                end
            end
            if (sq_valid_reg)
            begin
                tsq_reg <= tsq_reg + TSQ_W'(sq_reg);
            end
        end
    end

    assign status.rem_busy  = rem_busy;
    assign status.end_wraps = ($signed(e_ext) <= $signed(s_cmp));
    assign status.walk_last = (cnt_reg == IDX_W'(1));
    assign status.pipe_busy = rd_valid_reg | sq_valid_reg;

    assign max_value = max_reg;
    assign max_index = maxi_reg[IDX_OUT_W-1:0];
    assign min_value = min_reg;
    assign min_index = mini_reg[IDX_OUT_W-1:0];
    assign total     = tot_reg;
    assign total_abs = tabs_reg;
    assign total_sq  = tsq_reg;

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (cnt_reg != '0))
        else $error("window walk with no bins left");

    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (NW'(p_reg) < n_eff))
        else $error("read pointer beyond active bins");

endmodule

/* rtl/core/circular_window_profile_stats.sv */
// Top level of the circular window profile statistics block.
// Depends on cwps_pkg, cwps_ctrl, cwps_datapath (and cwps_rem below it).

// Usage: pulse start with an item while busy is low. A write item (opcode 0)
// stores bin_value at bin_index and never raises busy; indexes at or above
// MAX_BINS are dropped. A query item (opcode 1) raises busy until its single
// result, which appears on the result ports for exactly one cycle with done
// high; the receiver cannot stall, so capture it then. A query takes the
// remainder of its start magnitude against the bin count and, when the end
// phase does not lie above the start, also of start minus end: each remainder
// runs through one shared bit-serial unit at one bit per cycle, and the walk
// then reads one bin per cycle from the bin memory. Write active_bins only
// while busy is low; a value of 0 acts as 1 and one above MAX_BINS acts as
// MAX_BINS. Bins read by a query must have been written first. Indexes on
// the result ports are unwrapped phase indexes, and max/min report the first
// occurrence in the window.
module circular_window_profile_stats #(
    parameter int MAX_BINS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic [cwps_pkg::BIN_IDX_W-1:0]     bin_index,
    input  cwps_pkg::value_t                   bin_value,
    input  cwps_pkg::phase_t                   window_start,
    input  cwps_pkg::phase_t                   window_end,
    // configuration
    input  logic                               cfg_we,
    input  logic [cwps_pkg::CFG_W-1:0]         cfg_wdata,
    // results
    output logic                               done,
    output cwps_pkg::value_t                   max_value,
    output logic [cwps_pkg::IDX_OUT_W-1:0]     max_index,
    output cwps_pkg::value_t                   min_value,
    output logic [cwps_pkg::IDX_OUT_W-1:0]     min_index,
    output logic signed [cwps_pkg::TOT_W-1:0]  total,
    output logic [cwps_pkg::TABS_W-1:0]        total_abs,
    output logic [cwps_pkg::TSQ_W-1:0]         total_sq
);

    import cwps_pkg::*;

    cwps_cmd_t    cmd;
    cwps_status_t status;
    opcode_t      op;

    // Hold the opcode as its named code for the controller
    assign op = opcode_t'(opcode);

    // Controller: decides when to store, normalize, walk and strobe
    cwps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Datapath: memory, remainder unit, pointer and accumulators
    cwps_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .bin_index    (bin_index),
        .bin_value    (bin_value),
        .window_start (window_start),
        .window_end   (window_end),
        .max_value    (max_value),
        .max_index    (max_index),
        .min_value    (min_value),
        .min_index    (min_index),
        .total        (total),
        .total_abs    (total_abs),
        .total_sq     (total_sq)
    );

endmodule
